// ===== rtl/mrpt_pkg.sv =====
// package for the 64-bit miller-rabin prime test core
package mrpt_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned WitnessCnt = 12;
    localparam int unsigned WidxW = 4;
    localparam int unsigned BitW = 6;
    localparam int unsigned MulStepW = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECOMP,
        ST_WSEL,
        ST_POW_BIT,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_CHECK,
        ST_SQ_MUL,
        ST_SQ_CHECK,
        ST_DONE
    } mrpt_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SHIFT_D,
        OP_WIT_INIT,
        OP_MUL_ACC_BASE,
        OP_MUL_BASE_BASE,
        OP_MUL_ACC_ACC
    } mrpt_op_t;

    typedef struct packed {
        mrpt_op_t   op;
        logic [WidxW-1:0] widx;
    } mrpt_cmd_t;

    typedef struct packed {
        logic small_prime;
        logic small_comp;
        logic d_odd;
        logic wit_below;
        logic e_zero;
        logic e_lsb;
        logic mul_busy;
        logic x_one;
        logic x_nm1;
        logic r_last;
    } mrpt_status_t;

    function automatic logic [WordW-1:0] witness_value(input logic [WidxW-1:0] idx);
        logic [WordW-1:0] v;
        case (idx)
            4'd0:    v = 64'd2;
            4'd1:    v = 64'd3;
            4'd2:    v = 64'd5;
            4'd3:    v = 64'd7;
            4'd4:    v = 64'd11;
            4'd5:    v = 64'd13;
            4'd6:    v = 64'd17;
            4'd7:    v = 64'd19;
            4'd8:    v = 64'd23;
            4'd9:    v = 64'd29;
            4'd10:   v = 64'd31;
            4'd11:   v = 64'd37;
            default: v = 64'd37;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/miller_rabin_prime_test_64_core.sv =====
// top level of the 64-bit deterministic miller-rabin prime test core
// usage:
//   s_valid/s_ready/s_candidate carry one 64-bit number per transfer
//   m_valid/m_ready/m_is_prime return one bit per candidate, 1 when prime
// work per candidate:
//   small and even values go straight to ST_DONE, which then sets the registered m_valid
//   odd values: up to 12 witnesses, each a modular power of up to 126
//   multiplications plus up to 62 squarings; each multiplication is worked
//   bit-serially in the shift-and-add unit
// throughput:
//   one candidate at a time; the multiplier unit sets the figure
// reset:
//   aresetn low (synchronous) returns the controller to idle, no result pending
// stall:
//   a result held by m_ready low keeps the core from taking a new transfer
module miller_rabin_prime_test_64_core
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_WITNESSES = 12
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WordW-1:0] s_candidate,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_is_prime
);

    mrpt_cmd_t    cmd;
    mrpt_status_t status;

    mrpt_ctrl #(.NUM_WITNESSES(NUM_WITNESSES)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime),
        .status     (status),
        .cmd        (cmd)
    );

    mrpt_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cand_in (s_candidate),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// ===== rtl/mrpt_datapath.sv =====
// datapath: operand registers, shift-and-add modular multiplier, witness state
module mrpt_datapath
    import mrpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [WordW-1:0]   cand_in,
    input  mrpt_cmd_t          cmd,
    output mrpt_status_t       status
);

    localparam logic [1:0] DstAcc  = 2'd0;
    localparam logic [1:0] DstBase = 2'd1;
    localparam logic [1:0] DstSqr  = 2'd2;

    logic [WordW-1:0] n_reg, d_reg, e_reg, base_reg, acc_reg;
    logic [BitW-1:0]  s_reg, r_reg;
    logic [WordW-1:0] ma_reg, mb_reg, macc_reg;
    logic [MulStepW-1:0] mcnt_reg;
    logic             mbusy_reg;
    logic [1:0]       mdst_reg;

    logic [WordW-1:0] wit;
    logic [WordW:0]   dbl;
    logic [WordW-1:0] dbl_m, step_v;
    logic [WordW:0]   addv;
    logic [WordW-1:0] add_m;

    assign wit = witness_value(cmd.widx);

    // one multiplier step: double then conditional add, each reduced once
    always_comb begin
        dbl   = {1'b0, macc_reg} + {1'b0, macc_reg};
        dbl_m = (dbl >= {1'b0, n_reg}) ? WordW'(dbl - {1'b0, n_reg}) : dbl[WordW-1:0];
        addv  = {1'b0, dbl_m} + {1'b0, ma_reg};
        add_m = (addv >= {1'b0, n_reg}) ? WordW'(addv - {1'b0, n_reg}) : addv[WordW-1:0];
        step_v = mb_reg[WordW-1] ? add_m : dbl_m;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    n_reg <= cand_in;
                    d_reg <= cand_in - 64'd1;
                    s_reg <= '0;
                end
                OP_SHIFT_D: begin
                    d_reg <= d_reg >> 1;
                    s_reg <= s_reg + BitW'(1);
                end
                OP_WIT_INIT: begin
                    e_reg    <= d_reg;
                    base_reg <= wit;
                    acc_reg  <= 64'd1;
                    r_reg    <= BitW'(1);
                end
                OP_MUL_ACC_BASE, OP_MUL_BASE_BASE, OP_MUL_ACC_ACC: begin
                    ma_reg    <= (cmd.op == OP_MUL_ACC_BASE) ? acc_reg :
                                 (cmd.op == OP_MUL_BASE_BASE) ? base_reg : acc_reg;
                    mb_reg    <= (cmd.op == OP_MUL_ACC_ACC) ? acc_reg : base_reg;
                    mdst_reg  <= (cmd.op == OP_MUL_BASE_BASE) ? DstBase :
                                 (cmd.op == OP_MUL_ACC_ACC) ? DstSqr : DstAcc;
                    macc_reg  <= '0;
                    mcnt_reg  <= '0;
                    mbusy_reg <= 1'b1;
                end
                default: begin
                end
            endcase
            if (mbusy_reg) begin
                macc_reg <= step_v;
                mb_reg   <= mb_reg << 1;
                mcnt_reg <= mcnt_reg + MulStepW'(1);
                if (mcnt_reg == MulStepW'(WordW - 1)) begin
                    mbusy_reg <= 1'b0;
                    case (mdst_reg)
                        DstBase: begin
                            base_reg <= step_v;
                            e_reg    <= e_reg >> 1;
                        end
                        DstSqr: begin
                            acc_reg <= step_v;
                            r_reg   <= r_reg + BitW'(1);
                        end
                        default: acc_reg <= step_v;
                    endcase
                end
            end
        end
    end

    always_comb begin
        status.small_prime = (cand_in == 64'd2) || (cand_in == 64'd3);
        status.small_comp  = (cand_in < 64'd2) || !cand_in[0];
        status.d_odd       = d_reg[0];
        status.wit_below   = wit < n_reg;
        status.e_zero      = (e_reg == '0);
        status.e_lsb       = e_reg[0];
        status.mul_busy    = mbusy_reg;
        status.x_one       = (acc_reg == 64'd1);
        status.x_nm1       = (acc_reg == n_reg - 64'd1);
        status.r_last      = (r_reg >= s_reg);
    end

endmodule

// ===== rtl/mrpt_ctrl.sv =====
// controller state machine sequencing the witness rounds
module mrpt_ctrl
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_WITNESSES = 12
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_is_prime,
    input  mrpt_status_t status,
    output mrpt_cmd_t    cmd
);

    localparam int unsigned NW = (NUM_WITNESSES > WitnessCnt) ? WitnessCnt : NUM_WITNESSES;

    mrpt_state_t state_reg, state_next;
    logic [WidxW-1:0] widx_reg, widx_next;
    logic res_reg, res_next;
    logic mv_reg, mv_next;

    assign s_ready    = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid    = mv_reg;
    assign m_is_prime = res_reg;
    assign cmd.widx   = widx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            widx_reg  <= '0;
            res_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            res_reg   <= res_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        widx_next  = widx_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        cmd.op     = OP_NONE;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op    = OP_LOAD;
                    widx_next = '0;
                    if (status.small_prime) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (status.small_comp) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DECOMP;
                    end
                end
            end
            ST_DECOMP: begin
                if (status.d_odd) begin
                    state_next = ST_WSEL;
                end else begin
                    cmd.op = OP_SHIFT_D;
                end
            end
            ST_WSEL: begin
                if (widx_reg == WidxW'(NW)) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (!status.wit_below) begin
                    widx_next = widx_reg + WidxW'(1);
                end else begin
                    cmd.op     = OP_WIT_INIT;
                    state_next = ST_POW_BIT;
                end
            end
            ST_POW_BIT: begin
                if (status.e_zero) begin
                    state_next = ST_CHECK;
                end else if (status.e_lsb) begin
                    cmd.op     = OP_MUL_ACC_BASE;
                    state_next = ST_POW_MUL;
                end else begin
                    cmd.op     = OP_MUL_BASE_BASE;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL: begin
                if (!status.mul_busy) begin
                    cmd.op     = OP_MUL_BASE_BASE;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR: begin
                if (!status.mul_busy) begin
                    state_next = ST_POW_BIT;
                end
            end
            ST_CHECK: begin
                if (status.x_one || status.x_nm1) begin
                    widx_next  = widx_reg + WidxW'(1);
                    state_next = ST_WSEL;
                end else if (status.r_last) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_MUL_ACC_ACC;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                if (!status.mul_busy) begin
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_SQ_CHECK: begin
                if (status.x_nm1) begin
                    widx_next  = widx_reg + WidxW'(1);
                    state_next = ST_WSEL;
                end else if (status.x_one || status.r_last) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_MUL_ACC_ACC;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_DONE: begin
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_done_gives_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> m_valid)
        else $error("result not presented");
    a_widx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        widx_reg <= WidxW'(NW))
        else $error("witness index out of range");

endmodule

// ===== bench/miller_rabin_prime_test_64_core_test.sv =====
// testbench for the 64-bit miller-rabin prime test core
`timescale 1ns / 100ps

module miller_rabin_prime_test_64_core_test
    import mrpt_pkg::*;
;

    localparam int unsigned CycleLimit = 80_000_000;
    localparam logic [WordW-1:0] WitnessPrimes [12] = '{
        64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
        64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [WordW-1:0] s_candidate;
    logic             m_valid;
    logic             m_ready;
    logic             m_is_prime;

    logic             expected_prime_q [$];
    logic [WordW-1:0] expected_value_q [$];
    int unsigned      mismatch_cnt;
    int unsigned      cycle_cnt;
    bit               idling_on;
    int unsigned      hold_off_cycles;

    miller_rabin_prime_test_64_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_prime  (m_is_prime)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [WordW-1:0] mul_mod(input logic [WordW-1:0] a,
                                                 input logic [WordW-1:0] b,
                                                 input logic [WordW-1:0] m);
        logic [2*WordW-1:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod % {64'd0, m};
        return prod[WordW-1:0];
    endfunction

    function automatic logic [WordW-1:0] pow_mod(input logic [WordW-1:0] base,
                                                 input logic [WordW-1:0] e,
                                                 input logic [WordW-1:0] m);
        logic [WordW-1:0] acc;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, base, m);
            base = mul_mod(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic prime_by_witnesses(input logic [WordW-1:0] n);
        logic [WordW-1:0] d;
        logic [WordW-1:0] x;
        int unsigned      s;
        bit               passed;
        if (n < 2) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        if (!n[0]) return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < WitnessCnt; i++) begin
            if (WitnessPrimes[i] >= n) continue;
            x = pow_mod(WitnessPrimes[i], d, n);
            passed = (x == 1) || (x == n - 1);
            for (int r = 1; r < s && !passed; r++) begin
                x = mul_mod(x, x, n);
                if (x == n - 1) passed = 1'b1;
                else if (x == 1) break;
            end
            if (!passed) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    // one transfer on the input channel, with an optional random gap first
    task automatic send_candidate(input logic [WordW-1:0] value);
        if (idling_on && $urandom_range(0, 2) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_candidate = value;
        do @(posedge aclk); while (!s_ready);
        expected_prime_q.push_back(prime_by_witnesses(value));
        expected_value_q.push_back(value);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_prime_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                if (m_is_prime !== expected_prime_q[0])
                    report_mismatch($sformatf("candidate %0d is_prime %b, expected %b",
                        expected_value_q[0], m_is_prime, expected_prime_q[0]));
                void'(expected_prime_q.pop_front());
                void'(expected_value_q.pop_front());
            end
        end
    end

    // result side ready, with random stall bursts and the long hold-off
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready = 1'b0;
                hold_off_cycles--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    function automatic logic [WordW-1:0] random_candidate();
        logic [WordW-1:0] v;
        int unsigned      pick;
        int unsigned      width;
        pick = $urandom_range(0, 9);
        width = (pick < 7) ? $urandom_range(2, 20) :
                (pick < 9) ? $urandom_range(21, 40) : 64;
        v = {$urandom, $urandom};
        if (width < 64) v = v & ((64'd1 << width) - 1);
        if ($urandom_range(0, 4) != 0) v[0] = 1'b1;
        return v;
    endfunction

    task automatic test_small_values();
        for (int i = 0; i < 6; i++) send_candidate(64'(i));
    endtask

    task automatic test_even_values();
        send_candidate(64'd6);
        send_candidate(64'd1024);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
        send_candidate(64'h8000_0000_0000_0000);
    endtask

    // witnesses at or above n are skipped
    task automatic test_witness_skip();
        send_candidate(64'd37);
        send_candidate(64'd39);
        send_candidate(64'd41);
        send_candidate(64'd25);
    endtask

    task automatic test_pseudoprimes();
        send_candidate(64'd2047);
        send_candidate(64'd3215031751);
        send_candidate(64'd3825123056546413051);
    endtask

    task automatic test_large_values();
        send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
        send_candidate(64'd18446744073709551557);
        send_candidate(64'd4294967291);
    endtask

    // quick even values so a result is held while the next transfer waits
    task automatic test_backpressure();
        wait (expected_prime_q.size() == 0);
        @(negedge aclk);
        hold_off_cycles = 400;
        for (int i = 0; i < 4; i++) send_candidate(64'($urandom_range(2, 100)) << 1);
    endtask

    task automatic test_random(input int unsigned count);
        for (int i = 0; i < count; i++) send_candidate(random_candidate());
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_candidate = '0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        hold_off_cycles = 0;
        idling_on = 1'b1;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_small_values();
        test_even_values();
        test_witness_skip();
        test_pseudoprimes();
        test_large_values();
        test_backpressure();
        test_random(60);
        idling_on = 1'b0;
        test_random(20);
        s_valid = 1'b0;
        wait (expected_prime_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_prime_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
